// ----- design/fpa_pkg.sv -----
// fpa_pkg: shared constants, operation codes and pipeline payload types
// for the fixed-point ALU core. No dependencies.
package fpa_pkg;
   localparam int FracBits = 14;
   localparam int DataW    = 32;
   localparam int ModeW    = 4;
   localparam int QuoW     = 64;
   localparam int RemW     = 33;
   localparam int DivBitsPerStage = 2;
   localparam int DivStages = QuoW / DivBitsPerStage;

   typedef enum logic [ModeW-1:0] {
      OP_TO_FIXED = 4'd0,
      OP_TRUNC    = 4'd1,
      OP_ROUND    = 4'd2,
      OP_ADD      = 4'd3,
      OP_ADD_INT  = 4'd4,
      OP_SUB      = 4'd5,
      OP_SUB_INT  = 4'd6,
      OP_MUL      = 4'd7,
      OP_MUL_INT  = 4'd8,
      OP_DIV      = 4'd9,
      OP_DIV_INT  = 4'd10
   } op_type;

   // one division lane: magnitude dividend bits being shifted in, partial remainder
   typedef struct packed {
      logic              valid;
      logic              is_div;
      logic              neg;
      logic              dz;
      logic [DataW-1:0]  simple;
      logic [QuoW-1:0]   quo;
      logic [RemW-1:0]   rem;
      logic [DataW-1:0]  dsr;
   } div_lane_type;

   typedef struct packed {
      logic              valid;
      logic [DataW-1:0]  result;
      logic              dz;
   } out_type;
endpackage

// ----- design/fixed_point_alu_core.sv -----
// fixed_point_alu_core: top level; front stage, divider pipeline, output
// register. Depends on fpa_pkg, fpa_front, fpa_div_stage.
//
//  channel | dir | contents
//  req     | in  | tdata: mode[3:0], operand_a[35:4], operand_b[67:36]
//  rsp     | out | tdata: result[31:0], divide_by_zero[32]
//
// Every mode takes the same path; one transaction per cycle while rsp is not stalled.
// The 32-stage divider (two quotient bits per stage) sets the latency.
// Synchronous active-high reset clears all valid bits.
// A stall on rsp freezes the whole pipeline; nothing is lost or repeated.
module fixed_point_alu_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // mode, operand_a, operand_b
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // result, divide_by_zero
);
   import fpa_pkg::*;

   div_lane_type lanes [DivStages+1];
   out_type      out_ff, out_in;
   logic         en;
   logic [QuoW-1:0] q;
   logic [DataW-1:0] qd;

   assign en         = !out_ff.valid || rsp_tready;
   assign req_tready = en;

   fpa_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .mode     (req_tdata[3:0]),
      .a        (req_tdata[35:4]),
      .b        (req_tdata[67:36]),
      .lane     (lanes[0])
   );

   for (genvar g = 0; g < DivStages; g++) begin : g_div
      fpa_div_stage u_stage (
         .clock  (clock),
         .reset  (reset),
         .en     (en),
         .lane_i (lanes[g]),
         .lane_o (lanes[g+1])
      );
   end

   always_comb begin
      q  = lanes[DivStages].quo;
      qd = lanes[DivStages].neg ? DataW'(-q) : q[DataW-1:0];
      out_in.valid  = lanes[DivStages].valid;
      out_in.dz     = lanes[DivStages].dz;
      if (!lanes[DivStages].is_div) begin
         out_in.result = lanes[DivStages].simple;
      end else if (lanes[DivStages].dz) begin
         out_in.result = '0;
      end else begin
         out_in.result = qd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (en) begin
         out_ff.valid <= out_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff.result <= out_in.result;
         out_ff.dz     <= out_in.dz;
      end
   end

   assign rsp_tvalid = out_ff.valid;
   assign rsp_tdata  = {7'b0, out_ff.dz, out_ff.result};

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[32] |-> rsp_tdata[31:0] == '0)
      else $error("divide by zero with nonzero result");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked with empty output");
endmodule

// ----- design/fpa_front.sv -----
// fpa_front: decode stage. Computes simple modes and mul product, sets up
// magnitudes for the divider. Depends on fpa_pkg.
module fpa_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic [fpa_pkg::ModeW-1:0]      mode,
   input  logic signed [fpa_pkg::DataW-1:0] a,
   input  logic signed [fpa_pkg::DataW-1:0] b,
   output fpa_pkg::div_lane_type          lane
);
   import fpa_pkg::*;

   logic signed [63:0]   prod_ff, prod_in;
   logic [3:0]           mode_ff;
   logic signed [DataW-1:0] a_ff, b_ff;
   logic                 v_ff;
   logic [DataW-1:0]     simple;
   logic signed [DataW-1:0] half;
   logic signed [DataW:0] rnd;
   logic signed [63:0]   mq;
   logic [63:0]          ua, dvd;
   logic [DataW-1:0]     ub;
   logic                 isdiv, neg;

   assign prod_in = 64'(a) * 64'(b);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         mode_ff <= mode;
         a_ff    <= a;
         b_ff    <= b;
      end
   end

   always_comb begin
      half   = DataW'(1) <<< (FracBits - 1);
      rnd    = (a_ff >= 0) ? (33'(a_ff) + 33'(half)) : (33'(a_ff) - 33'(half));
      mq     = prod_ff;
      simple = '0;
      unique case (mode_ff)
         OP_TO_FIXED: simple = a_ff << FracBits;
         OP_TRUNC:    simple = DataW'((a_ff + ((a_ff < 0) ? ((DataW'(1) <<< FracBits) - 1) : 0))
                               >>> FracBits);
         OP_ROUND:    simple = DataW'((rnd + ((rnd < 0) ? ((33'(1) <<< FracBits) - 1) : 33'(0)))
                               >>> FracBits);
         OP_ADD:      simple = a_ff + b_ff;
         OP_ADD_INT:  simple = a_ff + (b_ff << FracBits);
         OP_SUB:      simple = a_ff - b_ff;
         OP_SUB_INT:  simple = a_ff - (b_ff << FracBits);
         OP_MUL:      simple = DataW'((mq + ((mq < 0) ? ((64'(1) <<< FracBits) - 1) : 64'(0)))
                               >>> FracBits);
         OP_MUL_INT:  simple = prod_ff[DataW-1:0];
         default:     simple = '0;
      endcase
      isdiv = (mode_ff == OP_DIV) || (mode_ff == OP_DIV_INT);
      neg   = a_ff[DataW-1] ^ b_ff[DataW-1];
      ua    = a_ff[DataW-1] ? 64'(-65'(a_ff)) : 64'(a_ff);
      ub    = b_ff[DataW-1] ? DataW'(-b_ff) : DataW'(b_ff);
      dvd   = (mode_ff == OP_DIV) ? (ua << FracBits) : ua;
   end

   assign lane.valid  = v_ff;
   assign lane.is_div = isdiv;
   assign lane.neg    = neg;
   assign lane.dz     = isdiv && (b_ff == '0);
   assign lane.simple = simple;
   assign lane.quo    = dvd;
   assign lane.rem    = '0;
   assign lane.dsr    = ub;
endmodule

// ----- design/fpa_div_stage.sv -----
// fpa_div_stage: one registered radix-2 restoring division stage
// retiring DivBitsPerStage quotient bits. Depends on fpa_pkg.
module fpa_div_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  fpa_pkg::div_lane_type lane_i,
   output fpa_pkg::div_lane_type lane_o
);
   import fpa_pkg::*;

   div_lane_type lane_ff, lane_in;
   logic [RemW-1:0] r;
   logic [QuoW-1:0] q;

   always_comb begin
      r = lane_i.rem;
      q = lane_i.quo;
      for (int i = 0; i < DivBitsPerStage; i++) begin
         r = {r[RemW-2:0], q[QuoW-1]};
         q = {q[QuoW-2:0], 1'b0};
         if (r >= RemW'(lane_i.dsr)) begin
            r    = r - RemW'(lane_i.dsr);
            q[0] = 1'b1;
         end
      end
      lane_in     = lane_i;
      lane_in.rem = r;
      lane_in.quo = q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else if (en) begin
         lane_ff.valid <= lane_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff.is_div <= lane_in.is_div;
         lane_ff.neg    <= lane_in.neg;
         lane_ff.dz     <= lane_in.dz;
         lane_ff.simple <= lane_in.simple;
         lane_ff.quo    <= lane_in.quo;
         lane_ff.rem    <= lane_in.rem;
         lane_ff.dsr    <= lane_in.dsr;
      end
   end

   assign lane_o = lane_ff;
endmodule

// ----- sim/fixed_point_alu_core_tb.sv -----
// fixed_point_alu_core_tb: self-checking bench for the fixed-point ALU core.
// Drives random and corner operations, predicts each result in place and
// compares in order. Depends on fpa_pkg and fixed_point_alu_core.
`timescale 1ns / 1ps

module fixed_point_alu_core_tb;
   import fpa_pkg::*;

   typedef struct packed {
      logic [ModeW-1:0] mode;
      logic [DataW-1:0] opa;
      logic [DataW-1:0] opb;
   } alu_op_type;

   typedef struct packed {
      logic [DataW-1:0] result;
      logic             dz;
   } alu_res_type;

   localparam int LatencyCycles = DivStages + 2;
   localparam int CycleLimit    = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   alu_op_type  pending_ops[$];
   alu_res_type expected_results[$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          hold_cycles = 0;
   bit          hold_request = 1'b0;
   bit          hold_taken = 1'b0;
   bit          req_stalled = 1'b0;
   bit          quiet_mode = 1'b0;

   fixed_point_alu_core dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic alu_res_type compute_alu(alu_op_type op);
      alu_res_type        r;
      logic signed [63:0] a, b, q;
      logic [DataW-1:0]   ua, ub;
      longint             scale;
      scale = 64'sd1 << FracBits;
      ua = op.opa;
      ub = op.opb;
      a  = $signed(op.opa);
      b  = $signed(op.opb);
      r  = '0;
      unique case (op.mode)
         OP_TO_FIXED: r.result = ua << FracBits;
         OP_TRUNC:    begin q = a / scale; r.result = q[31:0]; end
         OP_ROUND:    begin
            q = (a >= 0) ? (a + scale / 2) / scale : (a - scale / 2) / scale;
            r.result = q[31:0];
         end
         OP_ADD:      r.result = ua + ub;
         OP_ADD_INT:  r.result = ua + (ub << FracBits);
         OP_SUB:      r.result = ua - ub;
         OP_SUB_INT:  r.result = ua - (ub << FracBits);
         OP_MUL:      begin q = (a * b) / scale; r.result = q[31:0]; end
         OP_MUL_INT:  r.result = ua * ub;
         OP_DIV, OP_DIV_INT: begin
            if (b == 0) begin
               r.dz = 1'b1;
            end else begin
               q = (op.mode == OP_DIV) ? (a * scale) / b : a / b;
               r.result = q[31:0];
            end
         end
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] pick_operand();
      unique case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'(int'($urandom_range(0, 6)) - 3);
         3: return $urandom_range(0, 1) ? 32'h0000_4000 : 32'hffff_c000;
         4: return 32'($signed($urandom_range(0, 131071)) - 65536);
         5: return {{18{$urandom_range(0, 1) == 1}}, 14'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // transaction offered but not taken at this edge
   always @(posedge clock) begin
      req_stalled <= req_tvalid && !req_tready;
   end

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (req_stalled) begin
            // hold current transaction
         end else if (pending_ops.size() > 0 && (quiet_mode || $urandom_range(0, 99) >= 30)) begin
            req_tdata  <= {4'b0, pending_ops[0].opb, pending_ops[0].opa, pending_ops[0].mode};
            expected_results.push_back(compute_alu(pending_ops.pop_front()));
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver backpressure
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_request && !hold_taken) begin
            hold_taken  <= 1'b1;
            hold_cycles <= 199;
            rsp_tready  <= 1'b0;
         end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_tready  <= 1'b0;
         end else begin
            rsp_tready <= quiet_mode || $urandom_range(0, 99) >= 30;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      alu_res_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_tdata[31:0], 32'h0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata[31:0] !== want.result)
               report_mismatch("result", rsp_tdata[31:0], want.result);
            if (rsp_tdata[32] !== want.dz)
               report_mismatch("divide_by_zero", 32'(rsp_tdata[32]), 32'(want.dz));
         end
      end
   end

   initial begin
      alu_op_type op;
      logic [31:0] edges[6];
      edges = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h2000, 32'hffff_e000};
      for (int m = 0; m < 16; m++) begin
         op.mode = m[3:0];
         op.opa  = edges[m % 6];
         op.opb  = edges[(m + 3) % 6];
         pending_ops.push_back(op);
      end
      pending_ops.push_back('{OP_DIV, 32'h0001_0000, 32'h0});
      pending_ops.push_back('{OP_DIV_INT, 32'h8000_0000, 32'hffff_ffff});
      pending_ops.push_back('{OP_ROUND, 32'h0000_2000, 32'h0});
      pending_ops.push_back('{OP_ROUND, 32'hffff_e000, 32'h0});
      pending_ops.push_back('{OP_MUL, 32'h8000_0000, 32'h8000_0000});
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 1500; i++) begin
         op.mode = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                                : 4'($urandom_range(0, 10));
         op.opa  = pick_operand();
         op.opb  = ($urandom_range(0, 15) == 0) ? 32'h0 : pick_operand();
         pending_ops.push_back(op);
      end
      wait (pending_ops.size() < 1200);
      hold_request = 1'b1;
      wait (pending_ops.size() < 700);
      quiet_mode = 1'b1;
      wait (pending_ops.size() < 400);
      quiet_mode = 1'b0;
      wait (pending_ops.size() == 0 && !(req_tvalid && !req_tready));
      wait (expected_results.size() == 0);
      repeat (LatencyCycles + 10) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
